/* sv/text_pattern_matcher_unit_defines.svh */
// ----------------------------------------------------------------------------
// text pattern matcher assertion macros
// shared concurrent assertion forms, sampled on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef TEXT_PATTERN_MATCHER_UNIT_DEFINES_SVH
`define TEXT_PATTERN_MATCHER_UNIT_DEFINES_SVH

// condition holds at every sampled edge
`define TPM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define TPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define TPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/tpm_pkg.sv */
// ----------------------------------------------------------------------------
// tpm_pkg
// shared types, sizes, register indexes and character helpers
// ----------------------------------------------------------------------------
`default_nettype none

package tpm_pkg;

    // sizes
    localparam int MAX_PATTERN  = 16;
    localparam int COORD_WIDTH  = 16;
    localparam int PAT_BYTES    = 16;
    localparam int EFF_MAX      = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
    localparam int LEN_W        = 5;
    localparam int FILL_W       = $clog2(MAX_PATTERN + 2);
    localparam int FLAG_IDX_W   = $clog2(MAX_PATTERN + 1);
    localparam int COUNT_W      = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_WORD     = 3'd4;

    // input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } item_t;

    // result item
    typedef struct packed {
        logic [COORD_WIDTH-1:0] match_column;
        logic [COORD_WIDTH-1:0] match_line;
        logic [COUNT_W-1:0]     match_number;
    } result_t;

    // accepted match on its way from front to back
    typedef struct packed {
        logic                   valid;
        logic [COORD_WIDTH-1:0] column;
        logic [COORD_WIDTH-1:0] line;
    } match_push_t;

    // queue state seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // ascii lower-case fold
    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // letter, digit or underscore
    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

endpackage

`default_nettype wire

/* sv/tpm_front.sv */
// ----------------------------------------------------------------------------
// tpm_front
// config registers, character window, parallel compare and match decision
// ----------------------------------------------------------------------------
`default_nettype none

module tpm_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [tpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire tpm_pkg::item_t                  item,
    input  wire tpm_pkg::queue_status_t          q_status,
    output tpm_pkg::match_push_t                 push
);

    localparam int MP = tpm_pkg::MAX_PATTERN;
    localparam int CW = tpm_pkg::COORD_WIDTH;
    localparam int LW = tpm_pkg::LEN_W;
    localparam int FW = tpm_pkg::FILL_W;

    // configuration
    logic [63:0]   pat_low_reg;
    logic [63:0]   pat_high_reg;
    logic [LW-1:0] pat_len_reg;
    logic          match_case_reg;
    logic          whole_word_reg;

    // line state
    logic [7:0]    win_reg [MP];
    logic [7:0]    win_next [MP];
    logic [MP:0]   flags_reg, flags_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] line_reg, line_next;
    logic [LW-1:0] block_reg, block_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [CW-1:0] pend_col_reg, pend_col_next;
    logic          pend_wb_reg, pend_wb_next;

    logic          accept;
    logic [LW-1:0] eff_len;
    logic [8*tpm_pkg::PAT_BYTES-1:0] pat_all;
    logic [7:0]    pat_byte [tpm_pkg::PAT_BYTES];
    logic [7:0]    apat [MP];
    logic [MP-1:0] lane_ok;
    logic          hit;
    logic          after_word;
    logic          keep;

    assign item_ready = !q_status.full;
    assign accept     = item_valid && item_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg    <= '0;
            pat_high_reg   <= '0;
            pat_len_reg    <= '0;
            match_case_reg <= 1'b0;
            whole_word_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tpm_pkg::CFG_PATTERN_LOW:    pat_low_reg    <= cfg_data;
                tpm_pkg::CFG_PATTERN_HIGH:   pat_high_reg   <= cfg_data;
                tpm_pkg::CFG_PATTERN_LENGTH: pat_len_reg    <= cfg_data[LW-1:0];
                tpm_pkg::CFG_MATCH_CASE:     match_case_reg <= cfg_data[0];
                tpm_pkg::CFG_WHOLE_WORD:     whole_word_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the pattern length
    assign eff_len = (pat_len_reg > LW'(tpm_pkg::EFF_MAX)) ? LW'(tpm_pkg::EFF_MAX)
                                                          : pat_len_reg;

    // pattern bytes, then aligned so lane k faces the window slot k
    always_comb
    begin
        pat_all = {pat_high_reg, pat_low_reg};
        for (int i = 0; i < tpm_pkg::PAT_BYTES; i++)
        begin
            pat_byte[i] = pat_all[8*i +: 8];
        end
        for (int k = 0; k < MP; k++)
        begin
            apat[k] = pat_byte[4'(int'(eff_len) - 1 - k)];
        end
    end

    // window after taking this character, newest at slot zero
    always_comb
    begin
        win_next[0] = item.char_code;
        for (int k = 1; k < MP; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
        flags_next = {flags_reg[MP-1:0], tpm_pkg::is_word_char(item.char_code)};
    end

    // all lanes compare at once
    always_comb
    begin
        logic [7:0] t;
        logic [7:0] p;
        for (int k = 0; k < MP; k++)
        begin
            t = match_case_reg ? win_next[k] : tpm_pkg::fold_char(win_next[k]);
            p = match_case_reg ? apat[k] : tpm_pkg::fold_char(apat[k]);
            lane_ok[k] = (k >= int'(eff_len)) || (t == p);
        end
        hit = &lane_ok;
    end

    // decision on the match waiting for its right neighbour
    assign after_word = !item.line_end && tpm_pkg::is_word_char(item.char_code);
    assign keep       = !whole_word_reg || (!pend_wb_reg && !after_word);

    always_comb
    begin
        push.valid  = accept && pend_valid_reg && keep;
        push.column = pend_col_reg;
        push.line   = line_reg;
    end

    // next line state
    always_comb
    begin
        fill_next       = fill_reg;
        col_next        = col_reg;
        line_next       = line_reg;
        block_next      = block_reg;
        pend_valid_next = 1'b0;
        pend_col_next   = pend_col_reg;
        pend_wb_next    = pend_wb_reg;
        if (item.line_end)
        begin
            fill_next  = '0;
            col_next   = '0;
            block_next = '0;
            if (line_reg != '1)
            begin
                line_next = line_reg + 1'b1;
            end
        end
        else
        begin
            if (fill_reg != FW'(MP + 1))
            begin
                fill_next = fill_reg + 1'b1;
            end
            if (col_reg != '1)
            begin
                col_next = col_reg + 1'b1;
            end
            if (block_reg != '0)
            begin
                block_next = block_reg - 1'b1;
            end
            else if (eff_len != '0 && fill_next >= FW'(eff_len) && hit)
            begin
                pend_valid_next = 1'b1;
                pend_col_next   = col_reg - CW'(eff_len - 1'b1);
                pend_wb_next    = (fill_next > FW'(eff_len)) &&
                                  flags_next[tpm_pkg::FLAG_IDX_W'(eff_len)];
                block_next      = eff_len - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg      <= '0;
            fill_reg       <= '0;
            col_reg        <= '0;
            line_reg       <= '0;
            block_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_col_reg   <= '0;
            pend_wb_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (!item.line_end)
            begin
                flags_reg <= flags_next;
            end
            fill_reg       <= fill_next;
            col_reg        <= col_next;
            line_reg       <= line_next;
            block_reg      <= block_next;
            pend_valid_reg <= pend_valid_next;
            pend_col_reg   <= pend_col_next;
            pend_wb_reg    <= pend_wb_next;
        end
    end

    // character window, only read where the fill count covers it
    always_ff @(posedge clk)
    begin
        if (accept && !item.line_end)
        begin
            for (int k = 0; k < MP; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/tpm_queue.sv */
// ----------------------------------------------------------------------------
// tpm_queue
// short fifo of accepted matches between front and back
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_pattern_matcher_unit_defines.svh"

module tpm_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tpm_pkg::match_push_t        push,
    input  wire logic                        pop,
    output tpm_pkg::queue_status_t           status,
    output logic [tpm_pkg::COORD_WIDTH-1:0]  head_column,
    output logic [tpm_pkg::COORD_WIDTH-1:0]  head_line
);

    localparam int D  = tpm_pkg::QUEUE_DEPTH;
    localparam int PW = tpm_pkg::QPTR_W;
    localparam int NW = tpm_pkg::QCNT_W;
    localparam int CW = tpm_pkg::COORD_WIDTH;

    logic [CW-1:0] col_mem [D];
    logic [CW-1:0] line_mem [D];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign status.full  = (count_reg == NW'(D));
    assign status.empty = (count_reg == '0);
    assign do_push      = push.valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_column  = col_mem[rd_ptr_reg];
    assign head_line    = line_mem[rd_ptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(D - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(D - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            col_mem[wr_ptr_reg]  <= push.column;
            line_mem[wr_ptr_reg] <= push.line;
        end
    end

    // checks
    `TPM_ASSERT_ALWAYS(a_count_bound, count_reg <= NW'(D), "queue occupancy beyond depth")
    `TPM_ASSERT_SAME(a_no_push_full, push.valid, !status.full, "match pushed into full queue")
    `TPM_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "queue push lost")

endmodule

`default_nettype wire

/* sv/tpm_back.sv */
// ----------------------------------------------------------------------------
// tpm_back
// numbers accepted matches and holds the result item for the consumer
// ----------------------------------------------------------------------------
`default_nettype none

module tpm_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tpm_pkg::queue_status_t          q_status,
    input  wire logic [tpm_pkg::COORD_WIDTH-1:0] head_column,
    input  wire logic [tpm_pkg::COORD_WIDTH-1:0] head_line,
    output logic                                 pop,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output tpm_pkg::result_t                     result
);

    logic [tpm_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        valid_reg, valid_next;
    tpm_pkg::result_t            result_reg;

    // take the next match when the output slot is free or being emptied
    assign pop          = !q_status.empty && (!valid_reg || result_ready);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        count_next = count_reg;
        if (pop && count_reg != '1)
        begin
            count_next = count_reg + 1'b1;
        end
        valid_next = pop || (valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg.match_column <= head_column;
            result_reg.match_line   <= head_line;
            result_reg.match_number <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/text_pattern_matcher_unit.sv */
// a match is decided by the item after its last character; accepting that item
//   writes the match into the match queue, from which the output register takes it
// throughput: one item per cycle while the match queue is not full; all window lanes compare in parallel in the front
// a two-entry match queue and the output register let the sides stall separately
// reset: all control state and configuration registers clear at once, no sweep
// ----------------------------------------------------------------------------
// text_pattern_matcher_unit
// streaming fixed-pattern search with case folding and whole-word filtering
// ----------------------------------------------------------------------------
`default_nettype none

module text_pattern_matcher_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [tpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire tpm_pkg::item_t                  item,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output tpm_pkg::result_t                     result
);

    tpm_pkg::match_push_t                push;
    tpm_pkg::queue_status_t              q_status;
    logic                                pop;
    logic [tpm_pkg::COORD_WIDTH-1:0]     head_column;
    logic [tpm_pkg::COORD_WIDTH-1:0]     head_line;

    // classify items and decide matches
    tpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_status   (q_status),
        .push       (push)
    );

    // decouple the two sides
    tpm_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pop         (pop),
        .status      (q_status),
        .head_column (head_column),
        .head_line   (head_line)
    );

    // number and deliver results
    tpm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head_column  (head_column),
        .head_line    (head_line),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for text_pattern_matcher_unit: a short directed script,
// randomised phases of search settings with planted and broken pattern copies,
// a long output hold-off, and a closing stretch with no idling;
// every result item is compared with a typed expectation or an in-bench model of the search
// ----------------------------------------------------------------------------
module tb;

    import tpm_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int END_GAP       = 16;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 26;
    localparam int PHASE_ITEMS   = 30;
    localparam logic [COORD_WIDTH-1:0] COORD_TOP = {COORD_WIDTH{1'b1}};

    // ports
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;

    text_pattern_matcher_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // search settings as last written
    logic [63:0] pat_lo  = '0;
    logic [63:0] pat_hi  = '0;
    logic [4:0]  pat_len = '0;
    logic        exact   = 1'b0;
    logic        whole   = 1'b0;

    // search state
    logic [7:0]             win [MAX_PATTERN] = '{default: 8'h00};
    logic [MAX_PATTERN:0]   wflags      = '0;
    int unsigned            fill        = 0;
    int unsigned            block       = 0;
    logic [COORD_WIDTH-1:0] col_no      = '0;
    logic [COORD_WIDTH-1:0] line_no     = '0;
    logic                   pend        = 1'b0;
    logic [COORD_WIDTH-1:0] pend_col    = '0;
    logic                   pend_before = 1'b0;
    logic [COUNT_W-1:0]     n_accepted  = '0;

    // matches still owed by the block, oldest first
    result_t awaited_matches [$];

    // planned text for the running phase
    item_t text_plan [$];

    // bench control
    int  error_count     = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  settings_used   = 0;
    int  tx_idle_pct     = 0;
    int  rx_idle_pct     = 0;
    bit  calm            = 1'b0;
    bit  hold_request    = 1'b0;

    // directed script
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        item_t                 it;
        bit                    typed;
        result_t               want;
    } script_row_t;

    script_row_t script [$];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ascii upper case to lower case
    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // letter, digit or underscore
    function automatic logic word_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

    function automatic logic [7:0] pat_byte(input int unsigned i);
        if (i < 8)
        begin
            return pat_lo[8*i +: 8];
        end
        return pat_hi[8*(i-8) +: 8];
    endfunction

    // lengths beyond the pattern store act as the full store
    function automatic int unsigned eff_len();
        int unsigned n;
        n = pat_len;
        if (n > PAT_BYTES)
        begin
            n = PAT_BYTES;
        end
        if (n > MAX_PATTERN)
        begin
            n = MAX_PATTERN;
        end
        return n;
    endfunction

    // advance the search by one item; returns 1 when a match is reported
    function automatic bit search_step(input item_t it, output result_t res);
        bit                     found;
        logic                   after;
        bit                     hit;
        int unsigned            len;
        int                     k;
        logic [COORD_WIDTH-1:0] cur;
        logic [7:0]             t;
        logic [7:0]             p;
        found = 1'b0;
        res   = '0;

        // the new item is the right neighbour of a waiting raw match
        if (pend)
        begin
            after = it.line_end ? 1'b0 : word_byte(it.char_code);
            pend  = 1'b0;
            if (!whole || (!pend_before && !after))
            begin
                if (n_accepted != {COUNT_W{1'b1}})
                begin
                    n_accepted++;
                end
                res.match_column = pend_col;
                res.match_line   = line_no;
                res.match_number = n_accepted;
                found            = 1'b1;
            end
        end

        // line end clears the line state
        if (it.line_end)
        begin
            fill   = 0;
            col_no = '0;
            block  = 0;
            if (line_no != COORD_TOP)
            begin
                line_no++;
            end
            return found;
        end

        // shift in the character, newest at the front
        for (k = MAX_PATTERN - 1; k > 0; k--)
        begin
            win[k] = win[k-1];
        end
        win[0] = it.char_code;
        wflags = {wflags[MAX_PATTERN-1:0], word_byte(it.char_code)};
        if (fill < MAX_PATTERN + 1)
        begin
            fill++;
        end
        cur = col_no;
        if (col_no != COORD_TOP)
        begin
            col_no++;
        end

        // characters inside an earlier raw match cannot end a new one
        if (block > 0)
        begin
            block--;
            return found;
        end

        len = eff_len();
        if (len == 0 || fill < len)
        begin
            return found;
        end

        hit = 1'b1;
        for (k = 0; k < len; k++)
        begin
            t = win[len-1-k];
            p = pat_byte(k);
            if (!exact)
            begin
                t = lower_ascii(t);
                p = lower_ascii(p);
            end
            if (t != p)
            begin
                hit = 1'b0;
            end
        end
        if (hit)
        begin
            pend        = 1'b1;
            pend_col    = cur - COORD_WIDTH'(len - 1);
            pend_before = (fill > len) ? wflags[len] : 1'b0;
            block       = len - 1;
        end
        return found;
    endfunction

    // mismatch report
    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // offer one item and hold it until taken, then predict
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        result_t got;
        bit      found;
        if (!calm && $urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        found = search_step(it, got);
        if (typed)
        begin
            awaited_matches.insert(awaited_matches.size(), want);
        end
        else if (found)
        begin
            awaited_matches.insert(awaited_matches.size(), got);
        end
    endtask

    task automatic send_char(input logic [7:0] c);
        item_t it;
        it.char_code = c;
        it.line_end  = 1'b0;
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
        begin
            send_char(s[k]);
        end
    endtask

    task automatic send_eol();
        item_t it;
        it.char_code = 8'($urandom_range(0, 255));
        it.line_end  = 1'b1;
        send_item(it, 1'b0, '0);
    endtask

    // stop offering and let every owed match come out
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (awaited_matches.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, mirrored into the model
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_PATTERN_LOW:    pat_lo  = data;
            CFG_PATTERN_HIGH:   pat_hi  = data;
            CFG_PATTERN_LENGTH: pat_len = data[4:0];
            CFG_MATCH_CASE:     exact   = data[0];
            CFG_WHOLE_WORD:     whole   = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [4:0] len, input logic cs, input logic ww);
        wait_drained();
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_MATCH_CASE, CFG_DATA_W'(cs));
        write_reg(CFG_WHOLE_WORD, CFG_DATA_W'(ww));
        settings_used++;
    endtask

    // text bytes drawn from a small alphabet so that matches are common
    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'h61 + 8'($urandom_range(0, 3));
            3, 4:    return 8'h41 + 8'($urandom_range(0, 3));
            5:       return 8'h30 + 8'($urandom_range(0, 9));
            6:       return 8'h5F;
            7:       return 8'h20;
            8:       return 8'h2E;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // plan the next stretch of text: mostly pattern copies, some noise
    task automatic plan_chunk();
        int          kind;
        int          copies;
        int          k;
        int unsigned len;
        logic [7:0]  c;
        item_t       it;
        len = eff_len();
        if (len == 0)
        begin
            len = $urandom_range(1, 4);
        end
        kind = $urandom_range(0, 9);
        it.line_end = 1'b0;
        case (kind)
            0, 1, 2, 3, 4, 5:
            begin
                if ($urandom_range(0, 1))
                begin
                    it.char_code = text_byte();
                    text_plan.insert(text_plan.size(), it);
                end
                copies = (kind == 5) ? 2 : 1;
                repeat (copies)
                begin
                    for (k = 0; k < len; k++)
                    begin
                        c = pat_byte(k);
                        // random case when folding
                        if (!exact && (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A &&
                            $urandom_range(0, 1))
                        begin
                            c = c ^ 8'h20;
                        end
                        // broken copy
                        if (kind == 4 && k == len - 1)
                        begin
                            c = c + 8'h01;
                        end
                        it.char_code = c;
                        text_plan.insert(text_plan.size(), it);
                    end
                end
            end
            6:
            begin
                repeat ($urandom_range(1, 4))
                begin
                    it.char_code = 8'($urandom_range(0, 255));
                    text_plan.insert(text_plan.size(), it);
                end
            end
            7:
            begin
                repeat ($urandom_range(1, 4))
                begin
                    it.char_code = text_byte();
                    text_plan.insert(text_plan.size(), it);
                end
            end
            default:
            begin
                it.line_end  = 1'b1;
                it.char_code = (kind == 8) ? 8'h00 : 8'($urandom_range(0, 255));
                text_plan.insert(text_plan.size(), it);
            end
        endcase
    endtask

    // script builders
    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        script_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        script.insert(script.size(), row);
    endtask

    task automatic add_char(input logic [7:0] c);
        script_row_t row;
        row              = '{default: '0};
        row.it.char_code = c;
        script.insert(script.size(), row);
    endtask

    task automatic add_text(input string s);
        script_row_t row;
        int          k;
        row = '{default: '0};
        for (k = 0; k < s.len(); k++)
        begin
            row.it.char_code = s[k];
            script.insert(script.size(), row);
        end
    endtask

    task automatic add_eol();
        script_row_t row;
        row             = '{default: '0};
        row.it.line_end = 1'b1;
        row.it.char_code = 8'($urandom_range(0, 255));
        script.insert(script.size(), row);
    endtask

    task automatic typed_match(input int col, input int line, input int num);
        script[script.size()-1].typed              = 1'b1;
        script[script.size()-1].want.match_column  = COORD_WIDTH'(col);
        script[script.size()-1].want.match_line    = COORD_WIDTH'(line);
        script[script.size()-1].want.match_number  = COUNT_W'(num);
    endtask

    // result side: random short stalls, one long hold-off on request
    initial
    begin
        int hold;
        hold         = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                result_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold         = LONG_HOLD - 1;
                result_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < rx_idle_pct)
            begin
                hold         = $urandom_range(0, 2);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // result checking
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                results_checked++;
                if (awaited_matches.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected match column %0d line %0d number %0d",
                        result.match_column, result.match_line, result.match_number));
                end
                else
                begin
                    want = awaited_matches.pop_front();
                    if (result.match_column !== want.match_column)
                    begin
                        report_mismatch($sformatf("match_column %0d, wanted %0d",
                            result.match_column, want.match_column));
                    end
                    if (result.match_line !== want.match_line)
                    begin
                        report_mismatch($sformatf("match_line %0d, wanted %0d",
                            result.match_line, want.match_line));
                    end
                    if (result.match_number !== want.match_number)
                    begin
                        report_mismatch($sformatf("match_number %0d, wanted %0d",
                            result.match_number, want.match_number));
                    end
                end
            end
        end
    end

    // watchdog on handshake progress
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial
    begin
        int          ph;
        int          n;
        int          k;
        logic [127:0] pat;
        logic [4:0]  len;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        item_valid = 1'b0;
        item       = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern after reset, extreme bytes
        add_char(8'h00);
        add_char(8'hFF);
        add_eol();
        // folded search for "aB"
        add_cfg(CFG_PATTERN_LOW, 64'h4261);
        add_cfg(CFG_PATTERN_HIGH, {CFG_DATA_W{1'b1}});
        add_cfg(CFG_PATTERN_LENGTH, 2);
        add_cfg(CFG_MATCH_CASE, 0);
        add_cfg(CFG_WHOLE_WORD, 0);
        add_text("Abx");
        typed_match(0, 1, 1);
        add_text("aB");
        add_eol();
        typed_match(3, 1, 2);
        // exact and whole word: neighbours on either side reject
        add_cfg(CFG_MATCH_CASE, 1);
        add_cfg(CFG_WHOLE_WORD, 1);
        add_text(" aB_aB");
        add_eol();
        // settings change and empty pattern while a match waits
        add_text("aB");
        add_cfg(CFG_WHOLE_WORD, 0);
        add_cfg(CFG_PATTERN_LENGTH, 0);
        add_text("z");
        typed_match(0, 3, 3);
        add_eol();
        add_cfg(CFG_PATTERN_LENGTH, 2);
        // exact compare refuses other case
        add_text("Ab");
        add_eol();

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        foreach (script[r])
        begin
            if (script[r].is_cfg)
            begin
                wait_drained();
                write_reg(script[r].idx, script[r].data);
            end
            else
            begin
                send_item(script[r].it, script[r].typed, script[r].want);
            end
        end

        // random phases
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            for (k = 0; k < PAT_BYTES; k++)
            begin
                pat[8*k +: 8] = text_byte();
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = 5'($urandom_range(1, 4));
                6, 7:             len = 5'($urandom_range(5, 16));
                8:                len = 5'd16;
                default:          len = 5'($urandom_range(17, 31));
            endcase
            if (ph == 0)
            begin
                pat = '0;
                len = 5'd16;
            end
            else if (ph == 1)
            begin
                pat = '1;
                len = 5'd31;
            end
            else if (ph == 2)
            begin
                len = 5'd0;
            end
            else if (ph == 3)
            begin
                len = 5'd1;
            end
            apply_settings(pat[63:0], pat[127:64], len, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            case ($urandom_range(0, 2))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 10;
                default: tx_idle_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_idle_pct = 0;
                1:       rx_idle_pct = 10;
                default: rx_idle_pct = 35;
            endcase
            text_plan.delete();
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (text_plan.size() == 0)
                begin
                    plan_chunk();
                end
                send_item(text_plan.pop_front(), 1'b0, '0);
            end
        end

        // single-byte pattern on a run of matches, result side held off
        apply_settings(64'h61, 64'h0, 5'd1, 1'b1, 1'b0);
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        repeat (80) send_char(8'h61);
        // sender pause until all matches are out
        wait_drained();
        repeat (20) send_char(8'h61);

        // folded two-byte search, no idling from here on
        calm = 1'b1;
        apply_settings(64'h6261, {CFG_DATA_W{1'b1}}, 5'd2, 1'b0, 1'b0);
        send_eol();
        send_text("ab. AB ab.");
        send_eol();
        send_text("AB ab.");
        send_eol();
        // last match left waiting for a right neighbour
        send_text("ab");

        wait_drained();
        repeat (END_GAP) @(posedge clk);

        $display("checked %0d matches from %0d text items under %0d search settings",
                 results_checked, items_sent, settings_used);
        $display("with an output hold-off, a mid-stream pause and an idle-free tail");
        if (error_count == 0 && awaited_matches.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
